[design/rnd_pkg.sv]
// Package: payload types, status codes, sequencer states and control/status types for the rational unit.
`default_nettype none
package rnd_pkg;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] num_a;
    logic signed [31:0] den_a;
    logic signed [31:0] num_c;
    logic signed [31:0] den_c;
  } rnd_in_t;

  typedef struct packed {
    logic signed [63:0] out_num;
    logic [62:0]        out_den;
    logic [1:0]         status;
  } rnd_out_t;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StZeroDen = 2'd1;
  localparam logic [1:0] StDivZero = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_GCD, S_GWAIT, S_DIVN, S_DIVNW, S_DIVD, S_DIVDW, S_STAGE,
    S_OUT
  } rnd_state_e;

  // datapath commands
  typedef enum logic [2:0] {
    C_NONE, C_LOAD, C_GSTEP, C_DSTART_N, C_DSTART_D, C_CAPN, C_CAPD, C_STAGE
  } rnd_cmd_e;

  typedef struct packed {
    rnd_cmd_e cmd;
    logic     next_phase; // after stage: go to second reduction
  } rnd_ctl_t;

  typedef struct packed {
    logic gcd_done;  // x==0 or y==0
    logic div_busy;
    logic div_done;
    logic early;     // result already settled (error / zero), set at load or stage
    logic two_pass;  // divide request needs second reduction
    logic phase;     // current phase
  } rnd_sts_t;

endpackage
`default_nettype wire

[design/rnd_div.sv]
// Radix-2 restoring divider, 64-bit unsigned, one quotient bit per cycle.
`default_nettype none
module rnd_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [63:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [63:0]      quot_o,
  output logic [63:0]      rem_o
);
  logic [63:0] q_q, q_d, r_q, r_d, dv_q, dv_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [64:0] trial;
  logic [64:0] shl;

  always_comb begin
    q_d = q_q; r_d = r_q; dv_d = dv_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    shl = {r_q, q_q[63]};
    trial = shl - {1'b0, dv_q};
    if (start_i) begin
      q_d = dividend_i; r_d = '0; dv_d = divisor_i; cnt_d = 7'd64; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        r_d = trial[63:0]; q_d = {q_q[62:0], 1'b1};
      end else begin
        r_d = shl[63:0]; q_d = {q_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; dv_q <= dv_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;
endmodule
`default_nettype wire

[design/rnd_datapath.sv]
// Datapath: operand split, gcd registers, shared divider, products and result.
`default_nettype none
module rnd_datapath (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rnd_pkg::rnd_in_t  item_i,
  input  wire rnd_pkg::rnd_ctl_t ctl_i,
  output rnd_pkg::rnd_sts_t    sts_o,
  output rnd_pkg::rnd_out_t    res_o
);
  import rnd_pkg::*;

  logic [63:0] x_q, y_q, n_q, d_q, qn_q, an_q, ad_q, cn_q, cd_q;
  logic        neg_q, negc_q, phase_q, early_q, two_q;
  logic [1:0]  st_q;
  logic [31:0] ma, da, mc, dc;
  logic        sa, sda, sc, sdc;
  logic        dstart;
  logic [63:0] dnd, dvs, dq, dr;
  logic        dbusy, ddone;
  logic        xgt;
  logic [63:0] p1, p2;
  logic        phase_active_div, qdiv_q;

  // magnitude of a 32-bit two's complement value, -2^31 maps to 2^31
  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  assign sa = item_i.num_a[31]; assign sda = item_i.den_a[31];
  assign sc = item_i.num_c[31]; assign sdc = item_i.den_c[31];
  assign ma = mag32(item_i.num_a); assign da = mag32(item_i.den_a);
  assign mc = mag32(item_i.num_c); assign dc = mag32(item_i.den_c);

  assign xgt = x_q > y_q;
  assign dstart = (ctl_i.cmd == C_GSTEP) || (ctl_i.cmd == C_DSTART_N)
                || (ctl_i.cmd == C_DSTART_D);
  always_comb begin
    dnd = xgt ? x_q : y_q;
    dvs = xgt ? y_q : x_q;
    case (ctl_i.cmd)
      C_DSTART_N: begin dnd = n_q; dvs = x_q + y_q; end
      C_DSTART_D: begin dnd = d_q; dvs = x_q + y_q; end
      default: ;
    endcase
  end

  rnd_div u_div (
    .clk_i, .rst_ni, .start_i(dstart), .dividend_i(dnd), .divisor_i(dvs),
    .busy_o(dbusy), .done_o(ddone), .quot_o(dq), .rem_o(dr)
  );

  // cross products, 32x32 each, inputs registered
  assign p1 = an_q[31:0] * cd_q[31:0];
  assign p2 = ad_q[31:0] * cn_q[31:0];

  logic gstep_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0; early_q <= 1'b0; two_q <= 1'b0; gstep_q <= 1'b0;
    end else begin
      case (ctl_i.cmd)
        C_LOAD: begin
          phase_q <= 1'b0; two_q <= item_i.mode;
          early_q <= (item_i.den_a == '0) || (ma == '0)
                   || (item_i.mode && ((item_i.den_c == '0) || (mc == '0)));
        end
        C_GSTEP: gstep_q <= xgt;
        C_STAGE: begin phase_q <= ctl_i.next_phase; early_q <= (p1 == '0); end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ddone && !(phase_active_div)) begin
      if (gstep_q) x_q <= dr; else y_q <= dr;
    end
    case (ctl_i.cmd)
      C_LOAD: begin
        neg_q <= sa ^ sda; negc_q <= sc ^ sdc;
        x_q <= {32'd0, ma}; y_q <= {32'd0, da};
        n_q <= {32'd0, ma}; d_q <= {32'd0, da};
        cn_q <= {32'd0, mc}; cd_q <= {32'd0, dc};
        if (item_i.den_a == '0 || (item_i.mode && item_i.den_c == '0))
          st_q <= StZeroDen;
        else if (item_i.mode && mc == '0) st_q <= StDivZero;
        else st_q <= StOk;
      end
      C_CAPN: qn_q <= dq;
      C_CAPD: begin
        if (!phase_q) begin
          an_q <= qn_q; ad_q <= dq;
          if (!two_q) begin n_q <= qn_q; d_q <= dq; end
        end else begin
          n_q <= qn_q; d_q <= dq;
        end
      end
      C_STAGE: begin
        // second pass: reduce (a.mag*c.den)/(a.den*c.mag)
        n_q <= p1; d_q <= p2; x_q <= p1; y_q <= p2; neg_q <= neg_q ^ negc_q;
      end
      default: ;
    endcase
  end

  // divider used for quotient extraction, not gcd steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) qdiv_q <= 1'b0;
    else if (ctl_i.cmd == C_GSTEP) qdiv_q <= 1'b0;
    else if (ctl_i.cmd == C_DSTART_N || ctl_i.cmd == C_DSTART_D) qdiv_q <= 1'b1;
  end
  assign phase_active_div = qdiv_q;

  // c reduced magnitudes are not needed: gcd of cross products gives same result
  assign sts_o.gcd_done = (x_q == '0) || (y_q == '0);
  assign sts_o.div_busy = dbusy;
  assign sts_o.div_done = ddone;
  assign sts_o.early    = early_q;
  assign sts_o.two_pass = two_q;
  assign sts_o.phase    = phase_q;

  always_comb begin
    res_o.status = st_q;
    if (early_q) begin
      res_o.out_num = '0; res_o.out_den = 63'd1;
    end else begin
      res_o.out_num = neg_q ? (~n_q + 64'd1) : n_q;
      res_o.out_den = d_q[62:0];
    end
  end
endmodule
`default_nettype wire

[design/rnd_ctrl.sv]
// Sequencer for load, gcd loop, quotient extraction and result hold.
`default_nettype none
module rnd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire rnd_pkg::rnd_sts_t sts_i,
  output rnd_pkg::rnd_ctl_t      ctl_o
);
  import rnd_pkg::*;

  rnd_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_LOAD;
      S_LOAD:  state_d = sts_i.early ? S_OUT : S_GCD;
      S_GCD:   state_d = sts_i.gcd_done ? S_DIVN : S_GWAIT;
      S_GWAIT: if (sts_i.div_done) state_d = S_GCD;
      S_DIVN:  state_d = S_DIVNW;
      S_DIVNW: if (sts_i.div_done) state_d = S_DIVD;
      S_DIVD:  state_d = S_DIVDW;
      S_DIVDW: if (sts_i.div_done)
                 state_d = (sts_i.two_pass && !sts_i.phase) ? S_STAGE : S_OUT;
      S_STAGE: state_d = S_GCD;
      S_OUT:   if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o.cmd = C_NONE;
    ctl_o.next_phase = 1'b1;
    in_stall_o = (state_q != S_IDLE);
    out_valid_o = (state_q == S_OUT);
    case (state_q)
      S_IDLE:  if (in_valid_i) ctl_o.cmd = C_LOAD;
      S_GCD:   ctl_o.cmd = sts_i.gcd_done ? C_DSTART_N : C_GSTEP;
      S_DIVNW: if (sts_i.div_done) ctl_o.cmd = C_CAPN;
      S_DIVD:  ctl_o.cmd = C_DSTART_D;
      S_DIVDW: if (sts_i.div_done) ctl_o.cmd = C_CAPD;
      S_STAGE: ctl_o.cmd = C_STAGE;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

[design/rational_normalize_divide_core.sv]
// Rational normalize/divide core: reduces a/b, or (a/b)/(c/d), to lowest terms.
// Each Euclid step is one divider run; a pass ends with numerator and denominator
// divides; errors and zero numerators skip to output; a divide runs two passes.
// Throughput: one transaction at a time; the 64-bit serial divider sets the rate.
// Reset: rst_ni asynchronous, active low; returns the sequencer to idle.
`default_nettype none
module rational_normalize_divide_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire rnd_pkg::rnd_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output rnd_pkg::rnd_out_t     out_data_o
);
  import rnd_pkg::*;

  rnd_ctl_t ctl;
  rnd_sts_t sts;
  rnd_in_t  item;

  // input only sampled at load, when accepted
  assign item = in_data_i;

  rnd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .ctl_o(ctl)
  );

  rnd_datapath u_dp (
    .clk_i, .rst_ni, .item_i(item), .ctl_i(ctl), .sts_o(sts), .res_o(out_data_o)
  );
endmodule
`default_nettype wire

[design/rnd_checker.sv]
// Port-level checker for the rational core, bound to the top level.
`default_nettype none
module rnd_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire rnd_pkg::rnd_out_t out_data_o
);
  import rnd_pkg::*;

  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.out_den != '0) else $error("zero denominator out");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != StOk) |-> (out_data_o.out_num == '0))
    else $error("error result not 0/1");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o)) else $error("payload moved");
endmodule

bind rational_normalize_divide_core rnd_checker u_chk (.*);
`default_nettype wire
